[src/squared_distance_transform_line_top_macros.svh]
// Assertion macros for the line distance transform block.
// Used by the top level only; relies on clk_i and rst_ni in scope.
`ifndef SQUARED_DISTANCE_TRANSFORM_LINE_TOP_MACROS_SVH
`define SQUARED_DISTANCE_TRANSFORM_LINE_TOP_MACROS_SVH

// same-cycle implication
`define SDTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sdtl_pkg.sv]
// Package for the line distance transform block: sizes, codes, limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdtl_pkg;
  localparam int unsigned MAX_LEN     = 1024;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned DIST_W      = 25;
  localparam int unsigned OUT_DATA_W  = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;
endpackage
`default_nettype wire

[src/sdtl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sdtl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[src/squared_distance_transform_line_top.sv]
// Top level of the line squared distance transform (lower envelope of parabolas).
// Depends on sdtl_pkg, sdtl_ram and squared_distance_transform_line_top_macros.svh.
//
// Usage:
//   Slave channel: tdata = sample [23:0]; tuser = action [0], sample_infinite [1];
//   tlast = line_end. Action load pushes one sample, action fetch asks for the
//   next result once the line has been closed by a load with tlast set.
//   Master channel: tdata = distance [24:0], zero padded to 32 bits;
//   tuser = distance_infinite; tlast = last position of the line.
//   Work per item, all on one shared 26x12 multiplier and the registered
//   read of the envelope RAMs: a load into an empty envelope or of an
//   infinite sample is done in the idle state; other loads square q and v,
//   compare twice and reload one entry per pop; a fetch reads and latches
//   entries up to its own, squares, then outputs (empty line: outputs only).
//   tready is low while an item is being worked on. A result waits in the
//   output register while the receiver stalls; loads are still taken then,
//   a fetch waits for the register to drain.
//   Reset clears the line state; the envelope RAMs need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "squared_distance_transform_line_top_macros.svh"
module squared_distance_transform_line_top #(
  parameter int unsigned MAX_LEN = sdtl_pkg::MAX_LEN
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [sdtl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // sample
  input  wire logic [sdtl_pkg::IN_USER_W-1:0]  s_axis_tuser_i,  // action, sample_infinite
  input  wire logic                            s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [sdtl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // distance, zero pad
  output logic                                 m_axis_tuser_o,  // distance_infinite
  output logic                                 m_axis_tlast_o
);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned SB    = sdtl_pkg::SAMPLE_BITS;
  localparam int unsigned NUM_W = ((2 * IDX_W > SB) ? 2 * IDX_W : SB) + 2;
  localparam int unsigned DEN_W = IDX_W + 2;
  localparam int unsigned P_W   = NUM_W + DEN_W;
  localparam int unsigned VTX_W = IDX_W + SB;
  localparam int unsigned BND_W = NUM_W + DEN_W;
  localparam int unsigned DW    = sdtl_pkg::DIST_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQQ, S_SQV, S_CMP1, S_CMP2, S_POPRD,
    F_RD, F_LATCH, F_MUL, F_SQ, F_OUT
  } state_e;

  state_e state_q;
  logic [CNT_W-1:0] count_q, pos_q;
  logic [IDX_W-1:0] top_q, si_q, q_q, cv_q, fpos_q;
  logic             empty_q, drain_q;
  logic [SB-1:0]    fq_q, cf_q, fval_q;
  logic signed [NUM_W-1:0] qq_q, snum_q, cbn_q, fbn_q;
  logic signed [DEN_W-1:0] sden_q, cbd_q, fbd_q;
  logic signed [P_W-1:0]   cmp_q;
  logic [DW-1:0]    res_dist_q, out_dist_q;
  logic             res_inf_q, out_inf_q, out_last_q, out_valid_q;

  logic signed [NUM_W-1:0] mul_a;
  logic signed [DEN_W-1:0] mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [NUM_W-1:0] snum_d;
  logic signed [DEN_W-1:0] sden_d;
  logic signed [IDX_W:0]   dq;
  logic [P_W:0]            dist_sum;
  logic                    pop, adv;
  logic [IDX_W-1:0]        v_raddr, b_raddr, waddr;
  logic                    we;
  logic [VTX_W-1:0]        v_wdata, v_rdata;
  logic [BND_W-1:0]        b_wdata, b_rdata;
  logic [SB-1:0]           in_fq;
  logic [IDX_W-1:0]        in_q, top_inc;
  logic                    in_acc, out_free, last;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_fq    = s_axis_tdata_i[SB-1:0];
  assign in_q     = drain_q ? '0 : count_q[IDX_W-1:0];
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign last     = (pos_q + CNT_W'(1)) == count_q;
  assign top_inc  = top_q + IDX_W'(1);
  assign dq       = $signed({1'b0, pos_q[IDX_W-1:0]}) - $signed({1'b0, fpos_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQQ: begin
        mul_a = $signed({{(NUM_W-IDX_W){1'b0}}, q_q});
        mul_b = $signed({{(DEN_W-IDX_W){1'b0}}, q_q});
      end
      S_SQV: begin
        mul_a = $signed({{(NUM_W-IDX_W){1'b0}}, cv_q});
        mul_b = $signed({{(DEN_W-IDX_W){1'b0}}, cv_q});
      end
      S_CMP1: begin
        mul_a = snum_q;
        mul_b = cbd_q;
      end
      S_CMP2: begin
        mul_a = cbn_q;
        mul_b = sden_q;
      end
      F_MUL: begin
        mul_a = $signed({{(NUM_W-IDX_W){1'b0}}, pos_q[IDX_W-1:0]});
        mul_b = fbd_q;
      end
      F_SQ: begin
        mul_a = $signed({{(NUM_W-IDX_W-1){dq[IDX_W]}}, dq});
        mul_b = $signed({{(DEN_W-IDX_W-1){dq[IDX_W]}}, dq});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = P_W'(mul_a) * P_W'(mul_b);
  assign snum_d = $signed({{(NUM_W-SB){1'b0}}, fq_q}) + qq_q
                - $signed({{(NUM_W-SB){1'b0}}, cf_q}) - prod[NUM_W-1:0];
  assign sden_d = ($signed({2'b00, q_q}) - $signed({2'b00, cv_q})) <<< 1;
  assign pop    = (top_q != '0) && (cmp_q <= prod);
  assign adv    = (si_q < top_q) && ($signed(P_W'(fbn_q)) < prod);
  assign dist_sum = {1'b0, prod} + {{(P_W+1-SB){1'b0}}, fval_q};

  always_comb begin
    we      = 1'b0;
    waddr   = top_inc;
    v_wdata = {fq_q, q_q};
    b_wdata = {sden_q, snum_q};
    v_raddr = top_q - IDX_W'(1);
    b_raddr = top_q - IDX_W'(1);
    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tuser_i[0] == sdtl_pkg::ACT_LOAD && !s_axis_tuser_i[1]
            && (drain_q || count_q < CNT_W'(MAX_LEN)) && (drain_q || empty_q)) begin
          we      = 1'b1;
          waddr   = '0;
          v_wdata = {in_fq, in_q};
          b_wdata = {DEN_W'(1), NUM_W'(0)};
        end
      end
      S_CMP2: begin
        we = !pop && (({1'b0, top_q} + CNT_W'(1)) < CNT_W'(MAX_LEN));
      end
      F_RD: begin
        v_raddr = si_q;
        b_raddr = si_q + IDX_W'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  sdtl_ram #(.WIDTH(VTX_W), .DEPTH(MAX_LEN)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  sdtl_ram #(.WIDTH(BND_W), .DEPTH(MAX_LEN)) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      top_q       <= '0;
      si_q        <= '0;
      empty_q     <= 1'b1;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser_i[0] == sdtl_pkg::ACT_LOAD) begin
            if (drain_q) begin
              top_q   <= '0;
              empty_q <= 1'b1;
              pos_q   <= '0;
              si_q    <= '0;
              drain_q <= 1'b0;
            end
            if (drain_q || count_q < CNT_W'(MAX_LEN)) begin
              count_q <= (drain_q ? CNT_W'(0) : count_q) + CNT_W'(1);
              if (!s_axis_tuser_i[1]) begin
                q_q  <= in_q;
                fq_q <= in_fq;
                if (drain_q || empty_q) begin
                  top_q   <= '0;
                  empty_q <= 1'b0;
                  cv_q    <= in_q;
                  cf_q    <= in_fq;
                  cbn_q   <= '0;
                  cbd_q   <= DEN_W'(1);
                end else begin
                  state_q <= S_SQQ;
                end
              end
            end else if (drain_q) begin
              count_q <= '0;
            end
            if (s_axis_tlast_i) begin
              drain_q <= 1'b1;
              pos_q   <= '0;
              si_q    <= '0;
            end
          end else if (in_acc && drain_q && pos_q < count_q) begin
            if (empty_q) begin
              res_dist_q <= '0;
              res_inf_q  <= 1'b1;
              state_q    <= F_OUT;
            end else begin
              state_q <= F_RD;
            end
          end
        end
        S_SQQ: begin
          qq_q    <= prod[NUM_W-1:0];
          state_q <= S_SQV;
        end
        S_SQV: begin
          snum_q  <= snum_d;
          sden_q  <= sden_d;
          state_q <= S_CMP1;
        end
        S_CMP1: begin
          cmp_q   <= prod;
          state_q <= S_CMP2;
        end
        S_CMP2: begin
          if (pop) begin
            top_q   <= top_q - IDX_W'(1);
            state_q <= S_POPRD;
          end else begin
            if (we) begin
              top_q <= top_inc;
              cv_q  <= q_q;
              cf_q  <= fq_q;
              cbn_q <= snum_q;
              cbd_q <= sden_q;
            end
            state_q <= S_IDLE;
          end
        end
        S_POPRD: begin
          {cf_q, cv_q}   <= v_rdata;
          {cbd_q, cbn_q} <= b_rdata;
          state_q        <= S_SQV;
        end
        F_RD: begin
          state_q <= F_LATCH;
        end
        F_LATCH: begin
          {fval_q, fpos_q} <= v_rdata;
          {fbd_q, fbn_q}   <= b_rdata;
          state_q          <= F_MUL;
        end
        F_MUL: begin
          if (adv) begin
            si_q    <= si_q + IDX_W'(1);
            state_q <= F_RD;
          end else begin
            state_q <= F_SQ;
          end
        end
        F_SQ: begin
          res_dist_q <= (dist_sum > (P_W+1)'(sdtl_pkg::DIST_MAX)) ? sdtl_pkg::DIST_MAX
                                                               : dist_sum[DW-1:0];
          res_inf_q  <= 1'b0;
          state_q    <= F_OUT;
        end
        F_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_dist_q  <= res_dist_q;
            out_inf_q   <= res_inf_q;
            out_last_q  <= last;
            pos_q       <= pos_q + CNT_W'(1);
            if (last) begin
              count_q <= '0;
              pos_q   <= '0;
              top_q   <= '0;
              si_q    <= '0;
              empty_q <= 1'b1;
              drain_q <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(sdtl_pkg::OUT_DATA_W-DW){1'b0}}, out_dist_q};
  assign m_axis_tuser_o  = out_inf_q;
  assign m_axis_tlast_o  = out_last_q;

  `SDTL_ASSERT_NOW(a_inf_zero, out_valid_q && out_inf_q, out_dist_q == '0, "infinite result not zero")
  `SDTL_ASSERT_NOW(a_empty_top, empty_q, top_q == '0, "empty envelope with nonzero top")
  `SDTL_ASSERT_NOW(a_scan_in_env, drain_q, si_q <= top_q, "scan index beyond envelope top")
  `SDTL_ASSERT_NEXT(a_pop_reads, state_q == S_CMP2 && pop, state_q == S_POPRD, "pop without reload")
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for squared_distance_transform_line_top.
// Streams load and fetch items, predicts each distance from its own parabola envelope,
// and checks the results in order. Depends on sdtl_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic        act;
    logic [23:0] smp;
    logic        inf;
    logic        endl;
  } line_item_t;

  typedef struct packed {
    logic [sdtl_pkg::DIST_W-1:0] dval;
    logic                        dinf;
    logic                        last;
  } dist_res_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [sdtl_pkg::IN_DATA_W-1:0] s_data = '0;
  logic [sdtl_pkg::IN_USER_W-1:0] s_user = '0;
  logic s_last = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [sdtl_pkg::OUT_DATA_W-1:0] m_data;
  logic m_user;
  logic m_last;

  line_item_t pending_items[$];
  dist_res_t  expected_dists[$];
  line_item_t cur_item;
  logic       in_taken = 1'b0;
  int         sent_cnt = 0;
  int         hold_cnt = 0;
  bit         hold_done = 0;
  int         idle_cycles = 0;
  int         errors = 0;

  longint env_pos[sdtl_pkg::MAX_LEN];
  longint env_val[sdtl_pkg::MAX_LEN];
  longint bnd_num[sdtl_pkg::MAX_LEN];
  longint bnd_den[sdtl_pkg::MAX_LEN];
  int     line_len, env_top, scan_pos, scan_idx;
  bit     env_empty, line_closed;

  squared_distance_transform_line_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void line_restart();
    line_len = 0; env_top = 0; env_empty = 1;
    scan_pos = 0; scan_idx = 0; line_closed = 0;
  endfunction

  function automatic void envelope_push(longint q, longint fq);
    longint sn, sd, v;
    if (env_empty) begin
      env_top = 0; env_pos[0] = q; env_val[0] = fq;
      bnd_num[0] = 0; bnd_den[0] = 1; env_empty = 0;
      return;
    end
    v = env_pos[env_top];
    sn = (fq + q * q) - (env_val[env_top] + v * v); sd = 2 * (q - v);
    while (env_top > 0 && sn * bnd_den[env_top] <= bnd_num[env_top] * sd) begin
      env_top--;
      v = env_pos[env_top];
      sn = (fq + q * q) - (env_val[env_top] + v * v); sd = 2 * (q - v);
    end
    if (env_top + 1 >= sdtl_pkg::MAX_LEN) return;
    env_top++;
    env_pos[env_top] = q; env_val[env_top] = fq;
    bnd_num[env_top] = sn; bnd_den[env_top] = sd;
  endfunction

  function automatic void predict_distance(line_item_t it);
    dist_res_t r;
    longint q, dq, t;
    if (it.act == sdtl_pkg::ACT_LOAD) begin
      if (line_closed) line_restart();
      if (line_len < sdtl_pkg::MAX_LEN) begin
        if (!it.inf) envelope_push(line_len, it.smp);
        line_len++;
      end
      if (it.endl) begin
        line_closed = 1; scan_pos = 0; scan_idx = 0;
      end
      return;
    end
    if (!line_closed || scan_pos >= line_len) return;
    q = scan_pos;
    r.dval = '0; r.dinf = 1'b1;
    r.last = (scan_pos + 1 == line_len);
    if (!env_empty) begin
      while (scan_idx < env_top && bnd_num[scan_idx+1] < q * bnd_den[scan_idx+1])
        scan_idx++;
      dq = q - env_pos[scan_idx];
      t = dq * dq + env_val[scan_idx];
      r.dval = (t > longint'(sdtl_pkg::DIST_MAX)) ? sdtl_pkg::DIST_MAX
                                                  : t[sdtl_pkg::DIST_W-1:0];
      r.dinf = 1'b0;
    end
    expected_dists.push_back(r);
    scan_pos++;
    if (r.last) line_restart();
  endfunction

  task automatic add_load(logic [23:0] smp, logic inf, logic endl);
    line_item_t it;
    it.act = sdtl_pkg::ACT_LOAD; it.smp = smp; it.inf = inf; it.endl = endl;
    pending_items.push_back(it);
  endtask

  task automatic add_fetch(int n);
    line_item_t it;
    it.act = sdtl_pkg::ACT_FETCH; it.inf = $urandom_range(0, 1);
    it.endl = $urandom_range(0, 1);
    repeat (n) begin
      it.smp = $urandom();
      pending_items.push_back(it);
    end
  endtask

  task automatic add_line(int n, int maxv, int inf_pct);
    logic [23:0] v;
    for (int i = 0; i < n; i++) begin
      v = (maxv < 0) ? 24'($urandom()) : 24'($urandom_range(0, maxv));
      add_load(v, $urandom_range(0, 99) < inf_pct, i == n - 1);
    end
  endtask

  // phase 0 none, 1 sender idle, 2 receiver stall, 3 both
  function automatic int idle_phase();
    return (sent_cnt / 150) % 4;
  endfunction

  function automatic int idle_pct();
    return (idle_phase() == 3) ? 8 : 48;
  endfunction

  initial begin
    int n, k;
    add_load(24'd0, 1'b0, 1'b0);
    add_load(24'hFFFFFF, 1'b0, 1'b0);
    add_load(24'h5A5A5A, 1'b1, 1'b0);
    add_load(24'd3, 1'b0, 1'b1);
    add_fetch(2);
    add_load(24'd7, 1'b0, 1'b1);
    add_fetch(2);
    add_fetch(2);
    add_load(24'hFFFFFF, 1'b1, 1'b0);
    add_load(24'h000001, 1'b1, 1'b1);
    add_fetch(3);
    add_load(24'd9, 1'b0, 1'b0);
    add_fetch(1);
    add_load(24'hA5A5A5, 1'b0, 1'b1);
    add_fetch(3);
    add_line(sdtl_pkg::MAX_LEN + 6, 300, 10);
    add_fetch(8);
    add_line(4, -1, 20);
    add_fetch(4);
    while (pending_items.size() < 1350) begin
      n = $urandom_range(1, 40);
      k = $urandom_range(0, 9);
      case (k)
        0: add_line(n, -1, 30);
        1: add_line(n, 50, 100);
        default: add_line(n, (k < 5) ? 100 : 5000, 20);
      endcase
      k = $urandom_range(0, 9);
      if (k == 0) add_fetch($urandom_range(0, n));
      else if (k == 1) add_fetch(n + $urandom_range(1, 3));
      else add_fetch(n);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_restart();
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_valid && s_ready;
      if (s_valid && s_ready) predict_distance(cur_item);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || in_taken)) begin
      if (pending_items.size() != 0 &&
          !(idle_phase() inside {1, 3} && $urandom_range(0, 99) < idle_pct())) begin
        cur_item = pending_items.pop_front();
        s_valid <= 1'b1;
        s_data <= cur_item.smp;
        s_user <= {cur_item.inf, cur_item.act};
        s_last <= cur_item.endl;
        sent_cnt <= sent_cnt + 1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!hold_done && sent_cnt >= 1200) begin
      hold_done <= 1;
      hold_cnt <= 400;
      m_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !(idle_phase() inside {2, 3} && $urandom_range(0, 99) < idle_pct());
    end
  end

  always @(posedge clk_i) begin
    dist_res_t e;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_dists.size() == 0) begin
        $display("%0t: unexpected result dist=%0d inf=%0b last=%0b",
                 $time, m_data[sdtl_pkg::DIST_W-1:0], m_user, m_last);
        errors++;
      end else begin
        e = expected_dists.pop_front();
        if (m_data !== sdtl_pkg::OUT_DATA_W'(e.dval) || m_user !== e.dinf ||
            m_last !== e.last) begin
          $display("%0t: expected dist=%0d inf=%0b last=%0b, got dist=%0d inf=%0b last=%0b",
                   $time, e.dval, e.dinf, e.last, m_data, m_user, m_last);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (pending_items.size() == 0 && !s_valid);
    wait (expected_dists.size() == 0);
    repeat (4 * sdtl_pkg::MAX_LEN) @(posedge clk_i);
    if (errors == 0 && expected_dists.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/sdtl_pkg.sv
src/sdtl_ram.sv
src/squared_distance_transform_line_top.sv
tb/tb.sv
